@@ rtl/trigger_to_midi_note_events_assert.svh @@
// ---------------------------------------------------------------------------
// trigger_to_midi_note_events assertion macros
// shared property wrappers, clocked on clk and disabled while rst is high
// ---------------------------------------------------------------------------
`ifndef TRIGGER_TO_MIDI_NOTE_EVENTS_ASSERT_SVH
`define TRIGGER_TO_MIDI_NOTE_EVENTS_ASSERT_SVH

// consequent checked in the same cycle
`define T2M_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked in the next cycle
`define T2M_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/t2m_pkg.sv @@
// ---------------------------------------------------------------------------
// t2m_pkg
// shared types, message codes and constants of the trigger to midi block
// ---------------------------------------------------------------------------
package t2m_pkg;

  localparam int TRIGGERS    = 4;
  localparam int CHANNELS    = 4;
  localparam int CH_W        = $clog2(CHANNELS);
  localparam int DETENT_BITS = 2;                 // detent of four counts
  localparam int SLOTS       = TRIGGERS + 2;      // start, stop, one per trigger
  localparam int SLOT_START  = 0;
  localparam int SLOT_STOP   = 1;
  localparam int SLOT_LANE0  = 2;

  localparam logic [1:0] KIND_ON    = 2'd0;
  localparam logic [1:0] KIND_OFF   = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_STOP  = 2'd3;

  localparam logic [6:0] NOTE_MAX = 7'd127;
  localparam logic [6:0] VEL_ON   = 7'd127;
  localparam logic [6:0] VEL_OFF  = 7'd0;

  localparam logic signed [15:0] POS_RESET = -16'sd999;
  localparam logic [4:0]         MIDI_CH_RESET = 5'd1;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] index;
    logic [6:0] note;
    logic [6:0] vel;
  } msg_t;

  typedef struct packed {
    logic hit;
    msg_t msg;
  } lane_t;

  typedef struct packed {
    logic [SLOTS-1:0] mask;
    msg_t [SLOTS-1:0] slot;
  } batch_t;

  function automatic logic [6:0] reset_note(input logic [CH_W-1:0] idx);
    logic [6:0] n;
    unique case (idx)
      2'd0:    n = 7'd21;
      2'd1:    n = 7'd37;
      2'd2:    n = 7'd53;
      default: n = 7'd77;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/trigger_to_midi_note_events.sv @@
// a poll's words are registered in the merge stage's a buffer, then moved to its b buffer to be offered
// one message word per cycle while out_ready is high; a poll yields up to six words, sent
// one after another through the single output port of the merge stage
// a poll that yields no word occupies no buffer
// reset (rst, synchronous): buffers empty, stopped, channel 0, notes 21 37 53 77,
// previous position -999, midi channel 1
// ---------------------------------------------------------------------------
// trigger_to_midi_note_events
// turns polls of trigger, button and encoder pins into midi style message words
// ---------------------------------------------------------------------------
module trigger_to_midi_note_events
  import t2m_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic [4:0]         cfg_data,
  // poll channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         trigger_levels,
  input  logic               select_button,
  input  logic signed [15:0] encoder_position,
  input  logic               start_button,
  input  logic               stop_button,
  // message channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         message_kind,
  output logic [1:0]         trigger_index,
  output logic [6:0]         note_number,
  output logic [6:0]         velocity,
  output logic               last
);

  // poll state
  logic [TRIGGERS-1:0]   prev_trig;
  logic                  prev_sel;
  logic signed [15:0]    prev_pos;
  logic [CH_W-1:0]       channel;
  logic [6:0]            notes [CHANNELS];
  logic                  running;
  // midi channel register; stored only, no word field carries it
  logic [4:0]            chan_reg;

  logic                  in_fire;
  logic                  start_ev;
  logic                  run_mid;
  logic                  stop_ev;
  logic                  running_next;
  logic [CH_W-1:0]       channel_next;
  logic                  step_en;
  logic                  pos_fell;
  logic [6:0]            cur_note;
  logic [6:0]            stepped_note;
  logic [6:0]            notes_next [CHANNELS];
  lane_t [TRIGGERS-1:0]  lanes;
  batch_t                new_batch;
  msg_t                  out_msg;

  assign in_fire = in_valid && in_ready;

  // start then stop in one poll: start flips running on, stop flips it back
  assign start_ev     = start_button && !running;
  assign run_mid      = running || start_ev;
  assign stop_ev      = stop_button && run_mid;
  assign running_next = run_mid && !stop_ev;

  // select button rising edge advances the channel, wrapping
  assign channel_next = channel + CH_W'(select_button && !prev_sel);

  // encoder moved onto a detent: step the selected channel's note
  assign step_en  = (encoder_position != prev_pos) &&
                    (encoder_position[DETENT_BITS-1:0] == '0);
  assign pos_fell = prev_pos > encoder_position;
  assign cur_note = notes[channel_next];

  always_comb begin
    // falling count raises the note, rising count lowers it, both saturate
    if (pos_fell) begin
      stepped_note = (cur_note == NOTE_MAX) ? cur_note : cur_note + 7'd1;
    end else begin
      stepped_note = (cur_note == 7'd0) ? cur_note : cur_note - 7'd1;
    end
    for (int c = 0; c < CHANNELS; c++) begin
      notes_next[c] = (step_en && (channel_next == CH_W'(c))) ? stepped_note : notes[c];
    end
  end

  // one lane per trigger, all reading the updated note table
  for (genvar i = 0; i < TRIGGERS; i++) begin : g_lane
    t2m_lane u_lane (
      .level_now    (trigger_levels[i]),
      .level_before (prev_trig[i]),
      .note         (notes_next[i]),
      .lane_index   (2'(i)),
      .lane         (lanes[i])
    );
  end

  // gather this poll's words in emit order: start, stop, triggers 0..3
  always_comb begin
    new_batch = '0;
    new_batch.mask[SLOT_START]       = start_ev;
    new_batch.slot[SLOT_START].kind  = KIND_START;
    new_batch.mask[SLOT_STOP]        = stop_ev;
    new_batch.slot[SLOT_STOP].kind   = KIND_STOP;
    for (int i = 0; i < TRIGGERS; i++) begin
      new_batch.mask[SLOT_LANE0+i] = lanes[i].hit;
      new_batch.slot[SLOT_LANE0+i] = lanes[i].msg;
    end
  end

  t2m_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .new_batch (new_batch),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_msg   (out_msg),
    .out_last  (last)
  );

  assign message_kind  = out_msg.kind;
  assign trigger_index = out_msg.index;
  assign note_number   = out_msg.note;
  assign velocity      = out_msg.vel;

  // state commits when the poll is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_trig <= '0;
      prev_sel  <= 1'b0;
      prev_pos  <= POS_RESET;
      channel   <= '0;
      running   <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        notes[c] <= reset_note(CH_W'(c));
      end
    end else if (in_fire) begin
      prev_trig <= trigger_levels;
      prev_sel  <= select_button;
      prev_pos  <= encoder_position;
      channel   <= channel_next;
      running   <= running_next;
      for (int c = 0; c < CHANNELS; c++) begin
        notes[c] <= notes_next[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_reg <= MIDI_CH_RESET;
    end else if (cfg_write) begin
      chan_reg <= cfg_data;
    end
  end

endmodule

@@ rtl/t2m_lane.sv @@
// ---------------------------------------------------------------------------
// t2m_lane
// edge detect on one trigger input and build its note message
// ---------------------------------------------------------------------------
module t2m_lane
  import t2m_pkg::*;
(
  input  logic       level_now,
  input  logic       level_before,
  input  logic [6:0] note,
  input  logic [1:0] lane_index,
  output lane_t      lane
);

  always_comb begin
    lane.hit        = level_now ^ level_before;
    // high level is released, low level is active
    lane.msg.kind   = level_now ? KIND_OFF : KIND_ON;
    lane.msg.index  = lane_index;
    lane.msg.note   = note;
    lane.msg.vel    = level_now ? VEL_OFF : VEL_ON;
  end

endmodule

@@ rtl/t2m_emit.sv @@
// ---------------------------------------------------------------------------
// t2m_emit
// merge stage: holds up to two polls, sends one message per ready cycle
// ---------------------------------------------------------------------------
module t2m_emit
  import t2m_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_fire,
  input  batch_t new_batch,
  output logic   in_ready,
  output logic   out_valid,
  input  logic   out_ready,
  output msg_t   out_msg,
  output logic   out_last
);

  logic             a_valid;
  batch_t           a_batch;
  logic [SLOTS-1:0] b_mask;
  msg_t [SLOTS-1:0] b_slot;
  logic [SLOTS-1:0] sel_bit;
  logic             out_fire;
  logic             b_done;
  logic             a_move;

  // lowest pending slot goes first
  assign sel_bit   = b_mask & (~b_mask + SLOTS'(1));
  assign out_valid = |b_mask;
  assign out_last  = (b_mask & ~sel_bit) == '0;
  assign out_fire  = out_valid && out_ready;
  assign b_done    = !out_valid || (out_fire && out_last);
  assign a_move    = a_valid && b_done;
  assign in_ready  = !a_valid || a_move;

  always_comb begin
    out_msg = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (sel_bit[k]) out_msg = b_slot[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_mask  <= '0;
    end else begin
      if (in_fire && (new_batch.mask != '0)) begin
        a_valid <= 1'b1;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
      if (a_move) begin
        b_mask <= a_batch.mask;
      end else if (out_fire) begin
        b_mask <= b_mask & ~sel_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) a_batch <= new_batch;
    if (a_move) b_slot <= a_batch.slot;
  end

endmodule

@@ rtl/t2m_checker.sv @@
// ---------------------------------------------------------------------------
// t2m_checker
// port level checks of the message channel, bound to the top level
// ---------------------------------------------------------------------------
`include "trigger_to_midi_note_events_assert.svh"

module t2m_checker
  import t2m_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] message_kind,
  input logic [1:0] trigger_index,
  input logic [6:0] note_number,
  input logic [6:0] velocity,
  input logic       last
);

  `T2M_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(message_kind) && $stable(note_number) && $stable(trigger_index) && $stable(last), "stalled word changed")
  `T2M_ASSERT_NOW(a_transport_clean, out_valid && (message_kind == KIND_START || message_kind == KIND_STOP), trigger_index == 2'd0 && note_number == 7'd0 && velocity == 7'd0, "start or stop word carries note data")
  `T2M_ASSERT_NOW(a_velocity, out_valid && (message_kind == KIND_ON || message_kind == KIND_OFF), (message_kind == KIND_ON && velocity == VEL_ON) || (message_kind == KIND_OFF && velocity == VEL_OFF), "note velocity mismatch")
  `T2M_ASSERT_NEXT(a_burst, out_valid && out_ready && !last, out_valid, "poll burst broken before last word")

endmodule

bind trigger_to_midi_note_events t2m_checker u_t2m_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .message_kind  (message_kind),
  .trigger_index (trigger_index),
  .note_number   (note_number),
  .velocity      (velocity),
  .last          (last)
);

@@ tb/sv/t2m_event_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// t2m_event_checker
// watches the poll and message channels, predicts the message words of each
// accepted poll and compares every accepted message word with the oldest one
// ---------------------------------------------------------------------------
module t2m_event_checker
  import t2m_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [4:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [3:0]         trigger_levels,
  input  logic               select_button,
  input  logic signed [15:0] encoder_position,
  input  logic               start_button,
  input  logic               stop_button,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         message_kind,
  input  logic [1:0]         trigger_index,
  input  logic [6:0]         note_number,
  input  logic [6:0]         velocity,
  input  logic               last,
  output int                 fail_count,
  output int                 pending
);

  localparam int DETENT_STEP = 1 << DETENT_BITS;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] index;
    logic [6:0] note;
    logic [6:0] vel;
    logic       last;
  } word_t;

  // mirrored block state
  logic [3:0]         trig_q;
  logic               sel_q;
  logic signed [15:0] pos_q;
  logic [CH_W-1:0]    chan_q;
  logic [6:0]         notes [TRIGGERS];
  logic               run_q;
  logic [4:0]         midi_ch;   // stored only, no word field carries it

  word_t expected_words [$];
  int    errors = 0;

  task automatic predict_poll(input logic [3:0] t, input logic s,
                              input logic signed [15:0] p, input logic st,
                              input logic sp);
    word_t batch [SLOTS];
    int    n;
    int    now_i;
    int    was_i;
    n = 0;
    if (st && !run_q) begin
      run_q = 1'b1;
      batch[n] = '{KIND_START, 2'd0, 7'd0, VEL_OFF, 1'b0};
      n++;
    end
    if (sp && run_q) begin
      run_q = 1'b0;
      batch[n] = '{KIND_STOP, 2'd0, 7'd0, VEL_OFF, 1'b0};
      n++;
    end
    if (s && !sel_q) chan_q = chan_q + 1'b1;
    sel_q = s;
    if (p != pos_q) begin
      now_i = p;
      was_i = pos_q;
      if (now_i % DETENT_STEP == 0) begin
        // position fell: note up, else note down, both saturating
        if (was_i > now_i) begin
          if (notes[chan_q] != NOTE_MAX) notes[chan_q] = notes[chan_q] + 7'd1;
        end else begin
          if (notes[chan_q] != 7'd0) notes[chan_q] = notes[chan_q] - 7'd1;
        end
      end
      pos_q = p;
    end
    for (int i = 0; i < TRIGGERS; i++) begin
      if (t[i] != trig_q[i]) begin
        if (t[i]) batch[n] = '{KIND_OFF, 2'(i), notes[i], VEL_OFF, 1'b0};
        else      batch[n] = '{KIND_ON, 2'(i), notes[i], VEL_ON, 1'b0};
        n++;
      end
    end
    trig_q = t;
    if (n > 0) batch[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_words.push_back(batch[i]);
  endtask

  always @(posedge clk) begin : watch
    word_t got;
    word_t want;
    if (rst) begin
      trig_q   = 4'd0;
      sel_q    = 1'b0;
      pos_q    = POS_RESET;
      chan_q   = '0;
      notes[0] = 7'd21;
      notes[1] = 7'd37;
      notes[2] = 7'd53;
      notes[3] = 7'd77;
      run_q    = 1'b0;
      midi_ch  = MIDI_CH_RESET;
      expected_words.delete();
    end else begin
      if (cfg_write) midi_ch = cfg_data;
      if (in_valid && in_ready)
        predict_poll(trigger_levels, select_button, encoder_position,
                     start_button, stop_button);
      if (out_valid && out_ready) begin
        got = '{message_kind, trigger_index, note_number, velocity, last};
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: kind %0d index %0d note %0d vel %0d last %0d",
                     got.kind, got.index, got.note, got.vel, got.last);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("kind/index/note/vel/last expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                       want.kind, want.index, want.note, want.vel, want.last,
                       got.kind, got.index, got.note, got.vel, got.last);
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_words.size();
  end

endmodule

@@ tb/sv/tb_trigger_to_midi_note_events.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_trigger_to_midi_note_events
// drives polls of trigger, button and encoder pins into the block with random
// gaps and output stalls; a checker beside the block predicts and compares
// every message word, this top only makes stimulus and gives the verdict
// ---------------------------------------------------------------------------
module tb_trigger_to_midi_note_events;
  import t2m_pkg::*;

  localparam int LIMIT  = 500000;   // cycles, far above the slowest legal run
  localparam int SETTLE = 8;        // cycles to let a wordless poll leave the block

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write;
  logic [4:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [3:0]         trigger_levels;
  logic               select_button;
  logic signed [15:0] encoder_position;
  logic               start_button;
  logic               stop_button;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         message_kind;
  logic [1:0]         trigger_index;
  logic [6:0]         note_number;
  logic [6:0]         velocity;
  logic               last;

  int fail_count;
  int pending;
  int cycles = 0;

  // stimulus bookkeeping: what was last sent, not a model of the block
  bit                 quiet;       // last part of the run: no idling anywhere
  bit                 gaps_on;     // sender idles in bursts while set
  int                 polls_sent;
  logic [3:0]         last_trig;
  logic               last_sel;
  logic signed [15:0] last_pos;
  logic [1:0]         chan_sent;   // channel the select presses should have reached

  trigger_to_midi_note_events uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .trigger_levels   (trigger_levels),
    .select_button    (select_button),
    .encoder_position (encoder_position),
    .start_button     (start_button),
    .stop_button      (stop_button),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .message_kind     (message_kind),
    .trigger_index    (trigger_index),
    .note_number      (note_number),
    .velocity         (velocity),
    .last             (last)
  );

  t2m_event_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .trigger_levels   (trigger_levels),
    .select_button    (select_button),
    .encoder_position (encoder_position),
    .start_button     (start_button),
    .stop_button      (stop_button),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .message_kind     (message_kind),
    .trigger_index    (trigger_index),
    .note_number      (note_number),
    .velocity         (velocity),
    .last             (last),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL trigger_to_midi_note_events");
      $finish;
    end
  end

  // receiver side: stall bursts between ready runs
  initial begin : receiver
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // one poll word; valid stays high into the next poll when no gap follows
  task automatic poll(input logic [3:0] t, input logic s, input logic signed [15:0] p,
                      input logic st, input logic sp);
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    // flip now and then so idle stretches and busy stretches alternate
    if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
    in_valid         <= 1'b1;
    trigger_levels   <= t;
    select_button    <= s;
    encoder_position <= p;
    start_button     <= st;
    stop_button      <= sp;
    do @(posedge clk); while (!in_ready);
    if (s && !last_sel) chan_sent = chan_sent + 2'd1;
    last_sel  = s;
    last_pos  = p;
    last_trig = t;
    polls_sent++;
  endtask

  // sender pauses until every predicted word has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // register write, only while the block is idle
  task automatic write_chan_reg(input logic [4:0] value);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // press and release select until the wanted channel is reached
  task automatic select_channel(input logic [1:0] target);
    while (chan_sent != target) begin
      poll(last_trig, 1'b0, last_pos, 1'b0, 1'b0);
      poll(last_trig, 1'b1, last_pos, 1'b0, 1'b0);
    end
  endtask

  // run of detent positions in one direction; note_up means the count falls
  task automatic sweep(input int steps, input bit note_up, input bit hold_channel);
    int         base;
    int         pos_i;
    logic [3:0] t;
    logic       s;
    base = (int'($urandom_range(0, 2000)) - 1000) * 4;
    for (int k = 0; k < steps; k++) begin
      pos_i = note_up ? base - 4 * k : base + 4 * k;
      t = ($urandom_range(0, 2) == 0) ? 4'($urandom) : last_trig;
      s = hold_channel ? 1'b0 : ($urandom_range(0, 7) == 0);
      poll(t, s, 16'(pos_i), $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
    end
  endtask

  // one random stimulus pattern; mostly well-formed presses and detent runs
  task automatic random_item();
    int         pick;
    logic [3:0] t;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1: begin
        // pure noise on every pin
        poll(4'($urandom), 1'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
      end
      2, 3, 4: begin
        // trigger activity with the encoder resting or nudged
        t = 4'($urandom);
        if ($urandom_range(0, 1) == 0) poll(t, last_sel, last_pos, 1'b0, 1'b0);
        else poll(t, last_sel, last_pos + 16'(int'($urandom_range(0, 8)) - 4), 1'b0, 1'b0);
      end
      5, 6: begin
        sweep($urandom_range(4, 12), 1'($urandom), 1'b0);
      end
      7: begin
        // start and/or stop press, then release
        t = ($urandom_range(0, 1) == 0) ? 4'($urandom) : last_trig;
        case ($urandom_range(0, 2))
          0:       poll(t, last_sel, last_pos, 1'b1, 1'b0);
          1:       poll(t, last_sel, last_pos, 1'b0, 1'b1);
          default: poll(t, last_sel, last_pos, 1'b1, 1'b1);
        endcase
        poll(last_trig, last_sel, last_pos, 1'b0, 1'b0);
      end
      8: begin
        // select press and release
        poll(last_trig, 1'b1, last_pos, 1'b0, 1'b0);
        poll(4'($urandom), 1'b0, last_pos, 1'b0, 1'b0);
      end
      default: begin
        // pins held from the previous poll, start pressed now and then
        poll(last_trig, last_sel, last_pos, $urandom_range(0, 3) == 0, 1'b0);
      end
    endcase
  endtask

  initial begin : stimulus
    int  goal;
    bit  paused;
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_data         = MIDI_CH_RESET;
    in_valid         = 1'b0;
    trigger_levels   = 4'd0;
    select_button    = 1'b0;
    encoder_position = 16'sd0;
    start_button     = 1'b0;
    stop_button      = 1'b0;
    quiet            = 1'b0;
    gaps_on          = 1'b1;
    polls_sent       = 0;
    last_trig        = 4'd0;
    last_sel         = 1'b0;
    last_pos         = POS_RESET;
    chan_sent        = 2'd0;
    paused           = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    write_chan_reg(5'd16);

    // directed part
    // first poll: start and stop together, all triggers high give note-offs
    poll(4'b1111, 1'b0, 16'sd0, 1'b1, 1'b1);
    poll(4'b0000, 1'b0, 16'sd0, 1'b0, 1'b0);        // every trigger falls: note-ons
    poll(4'b0000, 1'b0, 16'sd0, 1'b1, 1'b0);        // start
    poll(4'b0000, 1'b0, 16'sd0, 1'b1, 1'b0);        // start held: nothing
    poll(4'b0101, 1'b0, -16'sd4, 1'b1, 1'b1);       // stop while running, negative detent
    poll(4'b0101, 1'b1, -16'sd8, 1'b0, 1'b0);       // select edge, count falls
    poll(4'b0101, 1'b1, -16'sd6, 1'b0, 1'b0);       // select held, off detent
    poll(4'b1010, 1'b0, 16'sh7FFC, 1'b0, 1'b0);     // count rises, all triggers flip
    poll(4'b1010, 1'b1, 16'sh8000, 1'b0, 1'b0);     // most negative count
    poll(4'b1010, 1'b0, 16'sh8000, 1'b0, 1'b1);     // stop while stopped: nothing
    poll(4'b1010, 1'b1, 16'sh7FFF, 1'b0, 1'b0);     // most positive count, off detent
    poll(4'b1010, 1'b0, 16'sh7FFF, 1'b0, 1'b0);     // position unchanged
    poll(4'b0000, 1'b1, 16'sd0, 1'b0, 1'b0);        // channel wraps to zero
    poll(4'b1111, 1'b0, 16'sd4, 1'b0, 1'b0);
    poll(4'b1110, 1'b0, 16'sd4, 1'b1, 1'b0);
    poll(4'b1101, 1'b0, 16'sd4, 1'b0, 1'b0);
    poll(4'b1011, 1'b0, 16'sd4, 1'b0, 1'b1);
    poll(4'b0111, 1'b0, 16'sd4, 1'b0, 1'b0);

    // notes driven into both bounds: highest note up, lowest note down
    select_channel(2'd3);
    sweep(60, 1'b1, 1'b1);
    select_channel(2'd0);
    sweep(30, 1'b0, 1'b1);

    // random phases, a register setting after each but the last
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 3) quiet = 1'b1;
      goal = polls_sent + 30;
      while (polls_sent < goal) begin
        random_item();
        // one pause mid-phase until every word is out
        if (phase == 1 && !paused && polls_sent >= goal - 15) begin
          drain();
          paused = 1'b1;
        end
      end
      case (phase)
        0:       write_chan_reg(5'd0);
        1:       write_chan_reg(5'd31);
        2:       write_chan_reg(5'($urandom_range(1, 16)));
        default: ;
      endcase
    end

    drain();
    repeat (SETTLE * 4) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS trigger_to_midi_note_events");
    end else begin
      $display("FAIL trigger_to_midi_note_events");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/t2m_pkg.sv
rtl/t2m_lane.sv
rtl/t2m_emit.sv
rtl/trigger_to_midi_note_events.sv
rtl/t2m_checker.sv
tb/sv/t2m_event_checker.sv
tb/sv/tb_trigger_to_midi_note_events.sv
